// ----- hw/rtl/greedy_box_nms_core_assert.svh -----
// ----------------------------------------------------------------------------
// greedy_box_nms_core_assert.svh - assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_NMS_CORE_ASSERT_SVH
`define GREEDY_BOX_NMS_CORE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define GBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication out of reset.
`define GBN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication out of reset.
`define GBN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/gbn_pkg.sv -----
// ----------------------------------------------------------------------------
// gbn_pkg - greedy box NMS package
// Beat types, store entry type, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned SIZE_W   = 15;
  localparam int unsigned AREA_W   = 2 * SIZE_W;
  localparam int unsigned THR_W    = 9;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned COUNT_W  = 7;

  localparam logic [THR_W-1:0] IOU_THRESH_RST = 9'd115;

  // Input beat: one box.
  typedef struct packed {
    logic                      first_of_set;
    logic signed [COORD_W-1:0] box_x;
    logic signed [COORD_W-1:0] box_y;
    logic        [SIZE_W-1:0]  box_w;
    logic        [SIZE_W-1:0]  box_h;
  } in_beat_t;

  // Output beat: one verdict.
  typedef struct packed {
    logic               keep;
    logic               store_full;
    logic [INDEX_W-1:0] box_index;
    logic [COUNT_W-1:0] kept_count;
  } out_beat_t;

  // One kept box in the store.
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic        [SIZE_W-1:0]  width;
    logic        [SIZE_W-1:0]  height;
    logic        [AREA_W-1:0]  area;
  } kept_entry_t;

  // Compare request into the overlap unit.
  typedef struct packed {
    logic        valid;
    kept_entry_t entry;
  } cmp_req_t;

  // Status back from the overlap unit.
  typedef struct packed {
    logic valid;
    logic suppress;
    logic busy;
  } cmp_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } nms_state_e;

endpackage

// ----- hw/rtl/gbn_iou_unit.sv -----
// ----------------------------------------------------------------------------
// gbn_iou_unit - pipelined overlap test
// Compares the current box with one kept box per cycle: intersection, union,
// and the scaled threshold test, over three register stages.
// ----------------------------------------------------------------------------
module gbn_iou_unit #(
  parameter int unsigned THRESH_FRAC_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gbn_pkg::cmp_req_t               req_i,
  input  gbn_pkg::in_beat_t               box_i,
  input  logic [gbn_pkg::AREA_W-1:0]      area_i,
  input  logic [gbn_pkg::THR_W-1:0]       thr_i,
  output gbn_pkg::cmp_stat_t              stat_o
);
  import gbn_pkg::*;

  localparam int unsigned EDGE_W = COORD_W + 2;
  localparam int unsigned UNI_W  = AREA_W + 1;
  localparam int unsigned PROD_W = UNI_W + THR_W;
  localparam int unsigned LHS_W  = AREA_W + THRESH_FRAC_BITS;
  localparam int unsigned CMP_W  = (LHS_W > PROD_W) ? LHS_W : PROD_W;

  logic                va_q, vb_q, vc_q;
  logic [SIZE_W-1:0]   iw_d, ih_d, iw_q, ih_q;
  logic [AREA_W-1:0]   karea_q;
  logic [AREA_W-1:0]   inter_q, inter2_q;
  logic [UNI_W-1:0]    sum_q, uni;
  logic [PROD_W-1:0]   prod_q;

  // Overlap extent along one axis, clamped at zero.
  function automatic logic [SIZE_W-1:0] extent(
    input logic signed [COORD_W-1:0] a, input logic [SIZE_W-1:0] al,
    input logic signed [COORD_W-1:0] b, input logic [SIZE_W-1:0] bl);
    logic signed [EDGE_W-1:0] a0, a1, b0, b1, lo, hi, d;
    a0 = {{2{a[COORD_W-1]}}, a};
    b0 = {{2{b[COORD_W-1]}}, b};
    a1 = a0 + $signed({3'b000, al});
    b1 = b0 + $signed({3'b000, bl});
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    d  = hi - lo;
    return (d > 0) ? d[SIZE_W-1:0] : '0;
  endfunction

  // Stage A: axis overlaps.
  always_comb begin
    iw_d = extent(box_i.box_x, box_i.box_w, req_i.entry.left, req_i.entry.width);
    ih_d = extent(box_i.box_y, box_i.box_h, req_i.entry.top, req_i.entry.height);
  end

  // Union from the registered intersection.
  assign uni = sum_q - {1'b0, inter_q};

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= req_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // Stage payloads: extents, then intersection and area sum, then product.
  always_ff @(posedge clk_i) begin
    iw_q     <= iw_d;
    ih_q     <= ih_d;
    karea_q  <= req_i.entry.area;
    inter_q  <= iw_q * ih_q;
    sum_q    <= UNI_W'(area_i) + UNI_W'(karea_q);
    inter2_q <= inter_q;
    prod_q   <= thr_i * uni;
  end

  // Threshold test on the last stage.
  always_comb begin
    stat_o.valid    = vc_q;
    stat_o.suppress = (CMP_W'(inter2_q) << THRESH_FRAC_BITS) > CMP_W'(prod_q);
    stat_o.busy     = va_q | vb_q | vc_q;
  end

endmodule

// ----- hw/rtl/greedy_box_nms_core.sv -----
// ----------------------------------------------------------------------------
// greedy_box_nms_core - greedy non-maximum suppression over sorted boxes
// Keeps each box that overlaps no earlier kept box of its set beyond the
// configured IoU threshold while the store has room; one verdict beat per box.
// ----------------------------------------------------------------------------
// Boxes arrive one per beat in falling score order; a beat with first_of_set
// starts a new set and empties the kept store. Each box is tested against
// every kept box of the set through one shared overlap pipeline that reads
// one store entry per cycle. With n boxes already kept in the set, in_stall_o
// stays high after a box is taken while the block scans the n kept entries,
// drains the read register and the three-stage pipeline and posts the
// verdict; with nothing kept yet the scan and drain are skipped. The verdict
// waits in an output register, and the next box is taken while it waits; a
// verdict that is ready while the previous one still waits holds the block
// until that one leaves. iou_threshold (thr_q, reset 115) is in units of
// 2^-THRESH_FRAC_BITS. The user must write it only while the block is idle;
// the block itself does not enforce this.
module greedy_box_nms_core #(
  parameter int unsigned MAX_KEPT         = 64,
  parameter int unsigned MAX_BOXES        = 1024,
  parameter int unsigned THRESH_FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  gbn_pkg::in_beat_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output gbn_pkg::out_beat_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [gbn_pkg::THR_W-1:0]     cfg_wdata_i
);
  import gbn_pkg::*;

  `include "greedy_box_nms_core_assert.svh"

  localparam int unsigned AW   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned KT_W = $clog2(MAX_KEPT + 1);
  localparam int unsigned SP_W = $clog2(MAX_BOXES);

  nms_state_e           state_q, state_d;
  logic [AW-1:0]        rd_idx_q, rd_idx_d;
  logic [KT_W-1:0]      kept_total_q, kept_total_d, total_eff;
  logic [SP_W-1:0]      set_pos_q, set_pos_d, pos_eff;
  logic [SP_W-1:0]      index_q, index_d;
  logic                 suppress_q, suppress_d;
  logic [THR_W-1:0]     thr_q;
  in_beat_t             box_q;
  logic [AREA_W-1:0]    area_q;
  logic                 rd_en, rd_valid_q;
  kept_entry_t          rd_data_q;
  logic                 wr_en;
  logic                 out_valid_q, out_valid_d, out_load;
  out_beat_t            out_data_q, out_data_d;
  logic                 accept, survive, full;
  cmp_req_t             req;
  cmp_stat_t            stat;

  kept_entry_t          store_mem [MAX_KEPT];

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Sequencer: accept, scan the store, drain the pipeline, post the verdict.
  always_comb begin
    state_d      = state_q;
    rd_idx_d     = rd_idx_q;
    kept_total_d = kept_total_q;
    set_pos_d    = set_pos_q;
    index_d      = index_q;
    suppress_d   = suppress_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    out_load     = 1'b0;
    total_eff    = in_data_i.first_of_set ? '0 : kept_total_q;
    pos_eff      = in_data_i.first_of_set ? '0 : set_pos_q;
    survive      = !suppress_q;
    full         = survive && (kept_total_q == KT_W'(MAX_KEPT));
    out_data_d   = out_data_q;

    if (stat.valid && stat.suppress) begin
      suppress_d = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kept_total_d = total_eff;
          index_d      = pos_eff;
          set_pos_d    = (pos_eff < SP_W'(MAX_BOXES - 1)) ? pos_eff + SP_W'(1) : pos_eff;
          suppress_d   = 1'b0;
          rd_idx_d     = '0;
          state_d      = (total_eff == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (KT_W'(rd_idx_q) + KT_W'(1) == kept_total_q) begin
          state_d = ST_DRAIN;
        end else begin
          rd_idx_d = rd_idx_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_valid_q && !stat.busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          wr_en    = survive && !full;
          out_load = 1'b1;
          if (wr_en) begin
            kept_total_d = kept_total_q + KT_W'(1);
          end
          out_data_d.keep       = wr_en;
          out_data_d.store_full = full;
          out_data_d.box_index  = INDEX_W'(index_q);
          out_data_d.kept_count = COUNT_W'(kept_total_d);
          state_d               = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the verdict until the consumer takes it.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kept_total_q <= '0;
      set_pos_q    <= '0;
      thr_q        <= IOU_THRESH_RST;
      rd_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      kept_total_q <= kept_total_d;
      set_pos_q    <= set_pos_d;
      rd_valid_q   <= rd_en;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    index_q    <= index_d;
    suppress_q <= suppress_d;
    out_data_q <= out_data_d;
    if (accept) begin
      box_q  <= in_data_i;
      area_q <= in_data_i.box_w * in_data_i.box_h;
    end
  end

  // Kept store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[kept_total_q[AW-1:0]] <= '{left:   box_q.box_x,
                                           top:    box_q.box_y,
                                           width:  box_q.box_w,
                                           height: box_q.box_h,
                                           area:   area_q};
    end
    if (rd_en) begin
      rd_data_q <= store_mem[rd_idx_q];
    end
  end

  assign req.valid = rd_valid_q;
  assign req.entry = rd_data_q;

  gbn_iou_unit #(
    .THRESH_FRAC_BITS(THRESH_FRAC_BITS)
  ) u_iou (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .box_i  (box_q),
    .area_i (area_q),
    .thr_i  (thr_q),
    .stat_o (stat)
  );

  // Checks on the sequencer and the store.
  `GBN_ASSERT(a_total_bound, kept_total_q <= KT_W'(MAX_KEPT), "kept count beyond store depth")
  `GBN_ASSERT_IMP(a_wr_room, wr_en, kept_total_q < KT_W'(MAX_KEPT), "store write while full")
  `GBN_ASSERT_IMP(a_verdict, out_valid_q, !(out_data_q.keep && out_data_q.store_full),
                  "box both kept and flagged full")
  `GBN_ASSERT_IMP(a_pipe_idle, rd_valid_q || stat.busy, state_q != ST_IDLE,
                  "compare in flight while idle")
  `GBN_ASSERT_NXT(a_keep_count, out_load && wr_en, kept_total_q == $past(kept_total_q) + KT_W'(1),
                  "kept count did not advance on store")

endmodule
